[rtl/core/tpcs_pkg.sv]
package tpcs_pkg;

  // ADC code width; the codes and the midpoint are taken modulo 2**ADC_BITS
  localparam int ADC_BITS = 12;

  localparam int GAIN_W = 16;   // Q8 milliamps per code
  localparam int LVL_W  = 19;   // trip / release level in mA
  localparam int CFG_W  = 19;   // widest register
  localparam int CFG_IDX_W = 2;

  localparam int PH_W   = 20;   // phase current, signed
  localparam int BETA_W = 21;   // beta, signed
  localparam int S_W    = PH_W + 2;  // a + 2b, signed

  // shift-add multiplier lanes, shared by all products
  localparam int MUL_W  = 21;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LVL2_W = 2 * LVL_W;

  localparam int PH_SHIFT   = 8;
  localparam int BETA_SHIFT = 15;

  localparam logic [MUL_W-1:0] INV_SQRT3_Q15 = MUL_W'(18919);

  localparam logic [PROD_W-1:0] PH_RND     = PROD_W'(1) << (PH_SHIFT - 1);
  localparam logic [PROD_W-1:0] PH_POS_LIM = (PROD_W'(1) << (PH_W - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] PH_NEG_LIM = PROD_W'(1) << (PH_W - 1);

  localparam logic [PROD_W-1:0] BETA_RND     = PROD_W'(1) << (BETA_SHIFT - 1);
  localparam logic [PROD_W-1:0] BETA_POS_LIM = (PROD_W'(1) << (BETA_W - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] BETA_NEG_LIM = PROD_W'(1) << (BETA_W - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_MIDPOINT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MA_PER_CODE_Q8 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_MA        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MA     = 2'd3;

  localparam logic [ADC_BITS-1:0] MIDPOINT_RST = ADC_BITS'(2048);
  localparam logic [GAIN_W-1:0]   GAIN_RST     = GAIN_W'(2063);
  localparam logic [LVL_W-1:0]    TRIP_RST     = LVL_W'(20000);
  localparam logic [LVL_W-1:0]    RELEASE_RST  = LVL_W'(18000);

  typedef struct packed {
    logic              start;
    logic [MUL_W-1:0]  mcand;
    logic [MUL_W-1:0]  mplier;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

[rtl/core/tpcs_if.sv]
interface tpcs_sample_if;
  logic                          valid;
  logic                          ready;
  logic [tpcs_pkg::ADC_BITS-1:0] phase_a_code;
  logic [tpcs_pkg::ADC_BITS-1:0] phase_b_code;
  logic [tpcs_pkg::ADC_BITS-1:0] phase_c_code;

  modport source (output valid, phase_a_code, phase_b_code, phase_c_code, input ready);
  modport sink   (input valid, phase_a_code, phase_b_code, phase_c_code, output ready);
endinterface

interface tpcs_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [tpcs_pkg::PH_W-1:0]   phase_a_ma;
  logic signed [tpcs_pkg::PH_W-1:0]   phase_b_ma;
  logic signed [tpcs_pkg::PH_W-1:0]   phase_c_ma;
  logic signed [tpcs_pkg::PH_W-1:0]   alpha_ma;
  logic signed [tpcs_pkg::BETA_W-1:0] beta_ma;
  logic                              oc_tripped;

  modport source (output valid, phase_a_ma, phase_b_ma, phase_c_ma, alpha_ma, beta_ma,
                  oc_tripped, input ready);
  modport sink   (input valid, phase_a_ma, phase_b_ma, phase_c_ma, alpha_ma, beta_ma,
                  oc_tripped, output ready);
endinterface

[rtl/core/tpcs_mul.sv]
// Radix-2 shift-add multiplier; one multiplier bit per cycle, stops as soon
// as the remaining multiplier bits are all zero.
module tpcs_mul (
  input  logic               clk,
  input  logic               rst,
  input  tpcs_pkg::mul_req_t req,
  output tpcs_pkg::mul_rsp_t rsp
);

  logic                          busy;
  logic [tpcs_pkg::PROD_W-1:0]   acc;
  logic [tpcs_pkg::PROD_W-1:0]   mcand;
  logic [tpcs_pkg::MUL_W-1:0]    mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy   <= 1'b1;
      acc    <= '0;
      mcand  <= tpcs_pkg::PROD_W'(req.mcand);
      mplier <= req.mplier;
    end else if (busy) begin
      if (mplier == '0) begin
        busy <= 1'b0;
      end else begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
    end
  end

  assign rsp.busy    = busy;
  assign rsp.product = acc;

endmodule

[rtl/core/three_phase_current_sense_clarke_unit.sv]
// Channel     Dir  Handshake      Payload
// cfg_*       in   cfg_we only    cfg_index (register), cfg_data (value)
// sample_in   in   valid/ready    phase_a_code, phase_b_code, phase_c_code
// result_out  out  valid/ready    phase_a/b/c_ma, alpha_ma, beta_ma, oc_tripped
//
// After the accepting edge, four rounds run on two bit-serial shift-add lanes;
// each round waits until both lanes have run out of multiplier bits (widths:
// |code - midpoint| 12, levels 19, 1/sqrt3 15, squares 20 and 21), then FIN
// loads the output register once free. sample_in.ready (sequencer idle) rises
// with result valid: one set in work at a time. Sync reset clears the
// flag, sequencer and output valid; a stalled result only holds the next FIN.
module three_phase_current_sense_clarke_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tpcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpcs_pkg::CFG_W-1:0]       cfg_data,
  tpcs_sample_if.sink                      sample_in,
  tpcs_result_if.source                    result_out
);

  // Sequencer. Each op state fires both lanes (go), waits for them, then
  // collects the products.
  //   PH0 : lane0 |dA|*gain        lane1 |dB|*gain
  //   PH1 : lane0 |dC|*gain        lane1 trip*trip
  //   BETA: lane0 |a+2b|*1/sqrt3   lane1 release*release
  //   SQ  : lane0 alpha^2          lane1 beta^2
  //   FIN : hysteresis compare, load output register
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PH0,
    ST_PH1,
    ST_BETA,
    ST_SQ,
    ST_FIN
  } state_t;

  state_t state;
  logic   go;

  // configuration
  logic [tpcs_pkg::ADC_BITS-1:0] adc_midpoint;
  logic [tpcs_pkg::GAIN_W-1:0]   ma_per_code_q8;
  logic [tpcs_pkg::LVL_W-1:0]    trip_ma;
  logic [tpcs_pkg::LVL_W-1:0]    release_ma;

  // working registers
  logic                              oc_flag;
  logic                              dneg_a, dneg_b, dneg_c;
  logic [tpcs_pkg::ADC_BITS-1:0]     dmag_a, dmag_b, dmag_c;
  logic signed [tpcs_pkg::PH_W-1:0]   a_ma, b_ma, c_ma;
  logic signed [tpcs_pkg::BETA_W-1:0] beta;
  logic [tpcs_pkg::LVL2_W-1:0]        trip2, rel2;
  logic [tpcs_pkg::PROD_W-1:0]        sum;

  // output register
  logic                              out_valid;
  logic signed [tpcs_pkg::PH_W-1:0]   out_a, out_b, out_c;
  logic signed [tpcs_pkg::BETA_W-1:0] out_beta;
  logic                              out_oc;

  tpcs_pkg::mul_req_t req0, req1;
  tpcs_pkg::mul_rsp_t rsp0, rsp1;

  logic [tpcs_pkg::ADC_BITS:0]   sm_a, sm_b, sm_c;
  logic signed [tpcs_pkg::S_W-1:0] s_sum;
  logic                            s_neg;
  logic [tpcs_pkg::MUL_W-1:0]      s_mag;
  logic [tpcs_pkg::PH_W-1:0]       a_mag;
  logic [tpcs_pkg::BETA_W-1:0]     beta_mag;
  logic                            lanes_done;
  logic                            out_free;
  logic                            oc_next;

  // {sign, |code - midpoint|}
  function automatic logic [tpcs_pkg::ADC_BITS:0] sign_mag(
    input logic [tpcs_pkg::ADC_BITS-1:0] code,
    input logic [tpcs_pkg::ADC_BITS-1:0] mid
  );
    logic [tpcs_pkg::ADC_BITS:0] d;
    logic [tpcs_pkg::ADC_BITS:0] m;
    d = {1'b0, code} - {1'b0, mid};
    m = d[tpcs_pkg::ADC_BITS] ? -d : d;
    return {d[tpcs_pkg::ADC_BITS], m[tpcs_pkg::ADC_BITS-1:0]};
  endfunction

  // round half away from zero (sign-magnitude), saturate, apply sign
  function automatic logic signed [tpcs_pkg::PH_W-1:0] ph_finish(
    input logic [tpcs_pkg::PROD_W-1:0] prod,
    input logic                        neg
  );
    logic [tpcs_pkg::PROD_W-1:0] r;
    logic [tpcs_pkg::PROD_W-1:0] lim;
    logic [tpcs_pkg::PH_W-1:0]   m;
    r   = (prod + tpcs_pkg::PH_RND) >> tpcs_pkg::PH_SHIFT;
    lim = neg ? tpcs_pkg::PH_NEG_LIM : tpcs_pkg::PH_POS_LIM;
    m   = (r > lim) ? lim[tpcs_pkg::PH_W-1:0] : r[tpcs_pkg::PH_W-1:0];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  function automatic logic signed [tpcs_pkg::BETA_W-1:0] beta_finish(
    input logic [tpcs_pkg::PROD_W-1:0] prod,
    input logic                        neg
  );
    logic [tpcs_pkg::PROD_W-1:0] r;
    logic [tpcs_pkg::PROD_W-1:0] lim;
    logic [tpcs_pkg::BETA_W-1:0] m;
    r   = (prod + tpcs_pkg::BETA_RND) >> tpcs_pkg::BETA_SHIFT;
    lim = neg ? tpcs_pkg::BETA_NEG_LIM : tpcs_pkg::BETA_POS_LIM;
    m   = (r > lim) ? lim[tpcs_pkg::BETA_W-1:0] : r[tpcs_pkg::BETA_W-1:0];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  assign sm_a = sign_mag(sample_in.phase_a_code, adc_midpoint);
  assign sm_b = sign_mag(sample_in.phase_b_code, adc_midpoint);
  assign sm_c = sign_mag(sample_in.phase_c_code, adc_midpoint);

  // a + 2b in sign-magnitude for the beta multiply
  always_comb begin
    s_sum = tpcs_pkg::S_W'(a_ma) + (tpcs_pkg::S_W'(b_ma) <<< 1);
    s_neg = s_sum[tpcs_pkg::S_W-1];
    s_mag = s_neg ? tpcs_pkg::MUL_W'(-s_sum) : tpcs_pkg::MUL_W'(s_sum);
  end

  assign a_mag    = a_ma[tpcs_pkg::PH_W-1] ? tpcs_pkg::PH_W'(-a_ma) : tpcs_pkg::PH_W'(a_ma);
  assign beta_mag = beta[tpcs_pkg::BETA_W-1] ? tpcs_pkg::BETA_W'(-beta)
                                             : tpcs_pkg::BETA_W'(beta);

  // lane operands follow the state; the lanes latch them on go
  always_comb begin
    req0.start  = go;
    req1.start  = go;
    req0.mcand  = '0;
    req0.mplier = '0;
    req1.mcand  = '0;
    req1.mplier = '0;
    case (state)
      ST_PH0: begin
        req0.mcand  = tpcs_pkg::MUL_W'(ma_per_code_q8);
        req0.mplier = tpcs_pkg::MUL_W'(dmag_a);
        req1.mcand  = tpcs_pkg::MUL_W'(ma_per_code_q8);
        req1.mplier = tpcs_pkg::MUL_W'(dmag_b);
      end
      ST_PH1: begin
        req0.mcand  = tpcs_pkg::MUL_W'(ma_per_code_q8);
        req0.mplier = tpcs_pkg::MUL_W'(dmag_c);
        req1.mcand  = tpcs_pkg::MUL_W'(trip_ma);
        req1.mplier = tpcs_pkg::MUL_W'(trip_ma);
      end
      ST_BETA: begin
        req0.mcand  = s_mag;
        req0.mplier = tpcs_pkg::INV_SQRT3_Q15;
        req1.mcand  = tpcs_pkg::MUL_W'(release_ma);
        req1.mplier = tpcs_pkg::MUL_W'(release_ma);
      end
      ST_SQ: begin
        req0.mcand  = tpcs_pkg::MUL_W'(a_mag);
        req0.mplier = tpcs_pkg::MUL_W'(a_mag);
        req1.mcand  = tpcs_pkg::MUL_W'(beta_mag);
        req1.mplier = tpcs_pkg::MUL_W'(beta_mag);
      end
      default: begin
      end
    endcase
  end

  tpcs_mul u_lane0 (.clk(clk), .rst(rst), .req(req0), .rsp(rsp0));
  tpcs_mul u_lane1 (.clk(clk), .rst(rst), .req(req1), .rsp(rsp1));

  // go is checked too: busy rises only the cycle after the start pulse
  assign lanes_done = !go && !rsp0.busy && !rsp1.busy;
  assign out_free   = !out_valid || result_out.ready;

  // set has priority over clear
  always_comb begin
    oc_next = oc_flag;
    if (sum > tpcs_pkg::PROD_W'(trip2)) begin
      oc_next = 1'b1;
    end else if (sum < tpcs_pkg::PROD_W'(rel2)) begin
      oc_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      go             <= 1'b0;
      oc_flag        <= 1'b0;
      out_valid      <= 1'b0;
      adc_midpoint   <= tpcs_pkg::MIDPOINT_RST;
      ma_per_code_q8 <= tpcs_pkg::GAIN_RST;
      trip_ma        <= tpcs_pkg::TRIP_RST;
      release_ma     <= tpcs_pkg::RELEASE_RST;
    end else begin
      go <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          tpcs_pkg::CFG_ADC_MIDPOINT:   adc_midpoint   <= cfg_data[tpcs_pkg::ADC_BITS-1:0];
          tpcs_pkg::CFG_MA_PER_CODE_Q8: ma_per_code_q8 <= cfg_data[tpcs_pkg::GAIN_W-1:0];
          tpcs_pkg::CFG_TRIP_MA:        trip_ma        <= cfg_data[tpcs_pkg::LVL_W-1:0];
          tpcs_pkg::CFG_RELEASE_MA:     release_ma     <= cfg_data[tpcs_pkg::LVL_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample_in.valid) begin
            dneg_a <= sm_a[tpcs_pkg::ADC_BITS];
            dneg_b <= sm_b[tpcs_pkg::ADC_BITS];
            dneg_c <= sm_c[tpcs_pkg::ADC_BITS];
            dmag_a <= sm_a[tpcs_pkg::ADC_BITS-1:0];
            dmag_b <= sm_b[tpcs_pkg::ADC_BITS-1:0];
            dmag_c <= sm_c[tpcs_pkg::ADC_BITS-1:0];
            state  <= ST_PH0;
            go     <= 1'b1;
          end
        end
        ST_PH0: begin
          if (lanes_done) begin
            a_ma  <= ph_finish(rsp0.product, dneg_a);
            b_ma  <= ph_finish(rsp1.product, dneg_b);
            state <= ST_PH1;
            go    <= 1'b1;
          end
        end
        ST_PH1: begin
          if (lanes_done) begin
            c_ma  <= ph_finish(rsp0.product, dneg_c);
            trip2 <= rsp1.product[tpcs_pkg::LVL2_W-1:0];
            state <= ST_BETA;
            go    <= 1'b1;
          end
        end
        ST_BETA: begin
          if (lanes_done) begin
            beta  <= beta_finish(rsp0.product, s_neg);
            rel2  <= rsp1.product[tpcs_pkg::LVL2_W-1:0];
            state <= ST_SQ;
            go    <= 1'b1;
          end
        end
        ST_SQ: begin
          if (lanes_done) begin
            sum   <= rsp0.product + rsp1.product;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // wait for the output register to drain before committing the flag
          if (out_free) begin
            oc_flag   <= oc_next;
            out_oc    <= oc_next;
            out_a     <= a_ma;
            out_b     <= b_ma;
            out_c     <= c_ma;
            out_beta  <= beta;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign sample_in.ready         = (state == ST_IDLE);
  assign result_out.valid        = out_valid;
  assign result_out.phase_a_ma   = out_a;
  assign result_out.phase_b_ma   = out_b;
  assign result_out.phase_c_ma   = out_c;
  assign result_out.alpha_ma     = out_a;
  assign result_out.beta_ma      = out_beta;
  assign result_out.oc_tripped   = out_oc;

endmodule

[rtl/core/tpcs_checker.sv]
module tpcs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [tpcs_pkg::PH_W-1:0]   out_a,
  input logic signed [tpcs_pkg::PH_W-1:0]   out_alpha,
  input logic signed [tpcs_pkg::BETA_W-1:0] out_beta,
  input logic                              out_oc
);

  // one set in flight: an accepted transaction closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous set still in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_beta)
                                && $stable(out_oc))
    else $error("stalled result changed");

  a_alpha_is_a: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_alpha == out_a)
    else $error("alpha differs from phase A");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind three_phase_current_sense_clarke_unit tpcs_checker u_tpcs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_in.valid),
  .in_ready  (sample_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_a     (result_out.phase_a_ma),
  .out_alpha (result_out.alpha_ma),
  .out_beta  (result_out.beta_ma),
  .out_oc    (result_out.oc_tripped)
);

[bench/tpcs_clarke_checker.sv]
module tpcs_clarke_checker
  import tpcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  tpcs_sample_if               smp,
  tpcs_result_if               res,
  output int                   fails,
  output int                   pending,
  output int                   checked,
  output int                   oc_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PH_HI     = (longint'(1) << (PH_W - 1)) - 1;
  localparam longint PH_LO     = -(longint'(1) << (PH_W - 1));
  localparam longint BETA_HI   = (longint'(1) << (BETA_W - 1)) - 1;
  localparam longint BETA_LO   = -(longint'(1) << (BETA_W - 1));
  localparam longint INV_SQRT3 = 18919;  // 1/sqrt(3) in Q15
  localparam int     GAIN_FRAC = 8;
  localparam int     K_FRAC    = 15;

  typedef struct packed {
    logic signed [PH_W-1:0]   phase_a;
    logic signed [PH_W-1:0]   phase_b;
    logic signed [PH_W-1:0]   phase_c;
    logic signed [PH_W-1:0]   alpha;
    logic signed [BETA_W-1:0] beta;
    logic                     oc_tripped;
  } currents_t;

  currents_t expected_currents[$];

  logic [ADC_BITS-1:0] midpoint    = MIDPOINT_RST;
  logic [GAIN_W-1:0]   gain        = GAIN_RST;
  logic [LVL_W-1:0]    trip_lvl    = TRIP_RST;
  logic [LVL_W-1:0]    release_lvl = RELEASE_RST;
  logic                oc_state    = 1'b0;

  int n_fail    = 0;
  int n_pending = 0;
  int n_checked = 0;
  int n_oc      = 0;

  assign fails   = n_fail;
  assign pending = n_pending;
  assign checked = n_checked;
  assign oc_seen = n_oc;

  // round to nearest, ties away from zero
  function automatic longint round_half_away(longint prod, int sh);
    longint mag;
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (prod < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint code_to_ma(logic [ADC_BITS-1:0] code);
    longint diff;
    diff = longint'(code) - longint'(midpoint);
    return clamp(round_half_away(diff * longint'(gain), GAIN_FRAC), PH_LO, PH_HI);
  endfunction

  // also advances the hysteresis flag
  function automatic currents_t predict_currents(logic [ADC_BITS-1:0] a_code,
                                                 logic [ADC_BITS-1:0] b_code,
                                                 logic [ADC_BITS-1:0] c_code);
    currents_t r;
    longint    a, b, c, beta, mag2;
    a    = code_to_ma(a_code);
    b    = code_to_ma(b_code);
    c    = code_to_ma(c_code);
    beta = clamp(round_half_away((a + 2 * b) * INV_SQRT3, K_FRAC), BETA_LO, BETA_HI);
    mag2 = a * a + beta * beta;
    if (mag2 > longint'(trip_lvl) * longint'(trip_lvl)) begin
      oc_state = 1'b1;
    end else if (mag2 < longint'(release_lvl) * longint'(release_lvl)) begin
      oc_state = 1'b0;
    end
    r.phase_a    = PH_W'(a);
    r.phase_b    = PH_W'(b);
    r.phase_c    = PH_W'(c);
    r.alpha      = PH_W'(a);
    r.beta       = BETA_W'(beta);
    r.oc_tripped = oc_state;
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    n_fail++;
  endtask

  task automatic check_field(string name, logic signed [BETA_W-1:0] got,
                             logic signed [BETA_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    currents_t want;
    if (rst) begin
      midpoint    = MIDPOINT_RST;
      gain        = GAIN_RST;
      trip_lvl    = TRIP_RST;
      release_lvl = RELEASE_RST;
      oc_state    = 1'b0;
      expected_currents.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ADC_MIDPOINT:   midpoint    = cfg_data[ADC_BITS-1:0];
          CFG_MA_PER_CODE_Q8: gain        = cfg_data[GAIN_W-1:0];
          CFG_TRIP_MA:        trip_lvl    = cfg_data[LVL_W-1:0];
          CFG_RELEASE_MA:     release_lvl = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        expected_currents.push_back(predict_currents(smp.phase_a_code, smp.phase_b_code,
                                                     smp.phase_c_code));
      end
      if (res.valid && res.ready) begin
        if (expected_currents.size() == 0) begin
          flag_error("result with no sample set outstanding");
        end else begin
          want = expected_currents.pop_front();
          check_field("phase_a_ma", res.phase_a_ma, want.phase_a);
          check_field("phase_b_ma", res.phase_b_ma, want.phase_b);
          check_field("phase_c_ma", res.phase_c_ma, want.phase_c);
          check_field("alpha_ma", res.alpha_ma, want.alpha);
          check_field("beta_ma", res.beta_ma, want.beta);
          check_field("oc_tripped", res.oc_tripped, want.oc_tripped);
          n_checked++;
          if (want.oc_tripped) n_oc++;
        end
      end
    end
    n_pending = expected_currents.size();
  end

endmodule

[bench/three_phase_current_sense_clarke_unit_tb.sv]
module three_phase_current_sense_clarke_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpcs_pkg::*;

  // generous guard against a hung run
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int CODE_MAX    = (1 << ADC_BITS) - 1;
  localparam int LVL_MAX     = (1 << LVL_W) - 1;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_SETS  = 250;
  localparam int TAIL_CYCLES = 200;  // tail watched for spurious results after the last drain

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ADC_MIDPOINT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // sample channel drive
  logic                set_valid = 1'b0;
  logic [ADC_BITS-1:0] code_a    = '0;
  logic [ADC_BITS-1:0] code_b    = '0;
  logic [ADC_BITS-1:0] code_c    = '0;
  // result channel drive
  logic                take_result = 1'b0;

  int  fails, pending, checked, oc_seen;
  int  cycles        = 0;
  int  sets_sent     = 0;
  int  settings_used = 0;
  int  stall_left    = 0;
  int  mid_now       = 2048;  // midpoint in force, used to center the codes
  bit  src_quiet     = 1'b0;  // no gaps between sample sets
  bit  sink_quiet    = 1'b0;  // result side never stalls

  tpcs_sample_if smp();
  tpcs_result_if res();

  assign smp.valid        = set_valid;
  assign smp.phase_a_code = code_a;
  assign smp.phase_b_code = code_b;
  assign smp.phase_c_code = code_c;
  assign res.ready        = take_result;

  three_phase_current_sense_clarke_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (smp),
    .result_out (res)
  );

  tpcs_clarke_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .smp       (smp),
    .res       (res),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked),
    .oc_seen   (oc_seen)
  );

  always #4 clk = ~clk;

  // Result back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      take_result <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!sink_quiet && $urandom_range(0, 99) < 25) begin
      take_result <= 1'b0;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(0, 3);
    end else begin
      take_result <= 1'b1;
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit, %0d results outstanding", pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Idle cycles before the next sample set: mostly none or a few, sometimes
  // long enough to land anywhere in the block's computation of the last set.
  function automatic int pick_gap();
    int r;
    if (src_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 90);
    return $urandom_range(100, 200);
  endfunction

  // Code within +/- amp of center, clipped to the ADC range
  function automatic logic [ADC_BITS-1:0] near_mid(int center, int amp);
    int v;
    v = center + int'($urandom_range(0, 2 * amp)) - amp;
    if (v < 0) v = 0;
    if (v > CODE_MAX) v = CODE_MAX;
    return v[ADC_BITS-1:0];
  endfunction

  // One transaction on the sample channel. valid is only lowered when a gap
  // follows, so back-to-back sets keep it high with a single assignment.
  task automatic send_set(input logic [ADC_BITS-1:0] a, input logic [ADC_BITS-1:0] b,
                          input logic [ADC_BITS-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      set_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    set_valid <= 1'b1;
    code_a    <= a;
    code_b    <= b;
    code_c    <= c;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    sets_sent++;
  endtask

  // Stop sending and wait for every outstanding result. Each sample set
  // yields exactly one result, so an empty checker queue means idle.
  task automatic drain();
    set_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles. Unused upper data bits
  // of the narrow registers carry junk; the block must ignore them.
  task automatic load_settings(input int mid, input int gain, input int trip,
                               input int rel);
    logic [CFG_W-1:0] word;
    word                 = CFG_W'($urandom);
    word[ADC_BITS-1:0]   = ADC_BITS'(mid);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ADC_MIDPOINT;
    cfg_data  <= word;
    @(posedge clk);
    word                 = CFG_W'($urandom);
    word[GAIN_W-1:0]     = GAIN_W'(gain);
    cfg_index <= CFG_MA_PER_CODE_Q8;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= CFG_TRIP_MA;
    cfg_data  <= CFG_W'(trip);
    @(posedge clk);
    cfg_index <= CFG_RELEASE_MA;
    cfg_data  <= CFG_W'(rel);
    @(posedge clk);
    cfg_we  <= 1'b0;
    mid_now = mid;
    settings_used++;
  endtask

  initial begin
    int mid, gain, lvl, trip, rel;
    int burst_left, amp;
    bit wild;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // Reset values written back explicitly; about 8 mA per code.
    load_settings(2048, 2063, 20000, 18000);
    send_set(2048, 2048, 2048);               // zero current
    send_set(4095, 4095, 4095);               // top code everywhere
    send_set(0, 0, 0);                        // bottom code everywhere
    send_set(4095, 0, 2048);
    send_set(0, 4095, 4095);
    // hysteresis walk: trip, hold inside the band, clear, hold low
    send_set(3548, 3548, 2048);               // ~24 A vector, sets
    send_set(2048, 4088, 2048);               // ~19 A, between levels, stays set
    send_set(2048, 2048, 2048);               // below release, clears
    send_set(2048, 4088, 2048);               // band again, stays clear
    // phase C is scaled but has no say in alpha/beta or the flag
    send_set(2048, 2048, 0);
    send_set(2048, 2048, 4095);

    // half-milliamp products: rounding away from zero on both signs
    drain();
    load_settings(2047, 128, 1, 0);
    send_set(2048, 2046, 2049);
    send_set(2046, 2048, 0);

    // full gain, zero midpoint: top codes saturate phase currents high
    drain();
    load_settings(0, 65535, LVL_MAX, LVL_MAX);
    send_set(4095, 4095, 4095);
    send_set(0, 0, 0);
    send_set(4095, 0, 1);

    // trip level below release: set test wins over clear
    drain();
    load_settings(4095, 65535, 1000, 50000);
    send_set(0, 0, 0);                        // negative saturation, sets
    send_set(4095, 4095, 4095);               // zero vector, clears
    send_set(4092, 4092, 4092);               // above trip and below release

    // zero gain, zero levels: sum equals both levels, flag holds
    drain();
    load_settings(4095, 0, 0, 0);
    send_set(0, 4095, 1234);

    // ---- random ----
    // Each phase picks a register setting with a trip level of at most 24 times
    // the gain, then sends bursts of sets around the midpoint with a per-burst
    // spread so the magnitude wanders across both levels.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      src_quiet  = (ph == 0);
      sink_quiet = (ph == 0) || (ph == 3);
      mid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, CODE_MAX)
                                        : $urandom_range(1900, 2200);
      case ($urandom_range(0, 3))
        0:       gain = $urandom_range(0, 255);
        3:       gain = $urandom_range(4001, 65535);
        default: gain = $urandom_range(1000, 4000);
      endcase
      lvl  = (gain * 24 > LVL_MAX) ? LVL_MAX : gain * 24;
      trip = $urandom_range(0, lvl);
      rel  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, LVL_MAX)
                                         : trip - int'($urandom_range(0, trip / 3));
      load_settings(mid, gain, trip, rel);

      burst_left = 0;
      amp        = 0;
      wild       = 1'b0;
      for (int n = 0; n < PHASE_SETS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          wild       = ($urandom_range(0, 99) < 15);
          case ($urandom_range(0, 3))
            0:       amp = 16;
            1:       amp = 300;
            2:       amp = 1200;
            default: amp = CODE_MAX;
          endcase
        end
        burst_left--;
        if (wild) begin
          // unconstrained codes, every bit of every field toggles
          send_set(ADC_BITS'($urandom_range(0, CODE_MAX)),
                   ADC_BITS'($urandom_range(0, CODE_MAX)),
                   ADC_BITS'($urandom_range(0, CODE_MAX)));
        end else begin
          send_set(near_mid(mid_now, amp), near_mid(mid_now, amp),
                   near_mid(mid_now, amp));
        end
      end
    end

    drain();
    // anything arriving now is a spurious result and the checker flags it
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d sample sets under %0d register settings, %0d results compared",
             sets_sent, settings_used, checked);
    $display("over-current high in %0d results, %0d mismatches", oc_seen, fails);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tpcs_pkg.sv
rtl/core/tpcs_if.sv
rtl/core/tpcs_mul.sv
rtl/core/three_phase_current_sense_clarke_unit.sv
rtl/core/tpcs_checker.sv
bench/tpcs_clarke_checker.sv
bench/three_phase_current_sense_clarke_unit_tb.sv
